[sv/sfwf_pkg.sv]
// shared constants, types and controller states for the sliding window flow features block
// depends on nothing; imported by sfwf_ram users, sfwf_div and sliding_window_flow_features
package sfwf_pkg;

	localparam int WINDOW   = 64;
	localparam int ADDR_W   = $clog2(WINDOW);
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int TS_W     = 40;
	localparam int SZ_W     = 16;
	localparam int RAM_W    = TS_W + SZ_W;
	localparam int TOT_W    = SZ_W + $clog2(WINDOW);
	localparam int SUM_W    = TS_W + $clog2(WINDOW);
	localparam int SQ_W     = 2 * TS_W + $clog2(WINDOW);
	localparam int NUM_W    = SQ_W + CNT_W;
	localparam int PROD_W   = SQ_W + SUM_W;
	localparam int HALF_W   = TS_W / 2;
	localparam int DVD_W    = NUM_W;
	localparam int DVS_W    = TS_W;
	localparam int ROOT_W   = TS_W + 1;
	localparam int SQV_W    = 2 * ROOT_W;
	localparam int REM_W    = ROOT_W + 3;
	localparam int STEP_W   = $clog2(SUM_W);
	localparam int US_W     = 20;
	localparam int PRATE_W  = 26;
	localparam int BRATE_W  = 42;
	localparam int FILL_W   = 7;
	localparam int FILL_MAX = 127;
	localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_SQR,
		ST_NUM,
		ST_PREP,
		ST_VAR,
		ST_SQRT,
		ST_MEAN,
		ST_PRATE,
		ST_BRATE,
		ST_SIZE,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[sv/sfwf_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
module sfwf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/sfwf_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on sfwf_pkg
module sfwf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sfwf_pkg::div_req_t req,
	output sfwf_pkg::div_rsp_t rsp
);
	import sfwf_pkg::*;

	localparam int DCNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              take;
	logic [DVS_W-1:0]  rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[DVD_W-1]};
		diff   = trial - {1'b0, dvs_q};
		take   = (trial >= {1'b0, dvs_q});
		rem_nx = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], take};
			rem_q <= rem_nx;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[sv/sliding_window_flow_features.sv]
// for two or more held arrivals the result is built by the ring sweep of one ram read per
// held arrival, a pipeline drain, two shift-add multiplies, a 41-step square root and five
// divisions on the shared 93-step divider; the first arrival goes straight to the output
// state; a new item is taken only once the controller is back in idle, and the output
// register lets the next item in while a result waits
// async reset clears the controller, write slot and fill count; ring contents stay undefined
module sliding_window_flow_features (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [sfwf_pkg::TS_W-1:0] arrival_time_us,
	input  logic [sfwf_pkg::SZ_W-1:0] pkt_len,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [39:0]               gap_mean_us,
	output logic [39:0]               gap_std_us,
	output logic [25:0]               packet_rate,
	output logic [41:0]               octet_rate,
	output logic [15:0]               mean_size,
	output logic [39:0]               duration_us,
	output logic [6:0]                fill_count
);
	import sfwf_pkg::*;

	st_t state_q, nxt;

	logic [ADDR_W-1:0] slot_q, slot_nx, start_addr, rd_addr_q;
	logic [ADDR_W:0]   start_sum;
	logic [CNT_W-1:0]  n_q, n_new, rd_cnt_q, gaps;
	logic [TS_W-1:0]   t_q, prev_q, first_q, span_q;
	logic              short_q;
	logic              accept;

	logic              ram_we, ram_re;
	logic [RAM_W-1:0]  ram_rdata;
	logic [TS_W-1:0]   rd_ts;
	logic [SZ_W-1:0]   rd_sz;

	logic              v_s1, first_s1, v_s2, v_s3;
	logic [TS_W-1:0]   g_s2;
	logic [TS_W-1:0]   hh_s3, hl_s3, ll_s3;
	logic [TOT_W-1:0]  total_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sumsq_q;

	logic [PROD_W-1:0] mul_a_q, mul_p_q, mul_p_next;
	logic [SUM_W-1:0]  mul_b_q;
	logic [STEP_W-1:0] step_q;
	logic              mul_last, sq_last;
	logic [2*SUM_W-1:0] s2_q;
	logic [NUM_W-1:0]  num_q;

	logic [SQV_W-1:0]  sq_val_q;
	logic [REM_W-1:0]  sq_rem_q, sq_rem2, sq_trial;
	logic [ROOT_W-1:0] sq_root_q, sq_root_nx;
	logic              sq_take;

	logic [TS_W-1:0]    mean_q, std_q;
	logic [PRATE_W-1:0] prate_q;
	logic [BRATE_W-1:0] brate_q;
	logic [SZ_W-1:0]    msize_q;

	logic [PRATE_W-1:0] pkts_us;
	logic [BRATE_W-1:0] octets_us;
	logic [2*CNT_W-1:0] gaps_sq;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     out_free;
	logic [15:0] n_wide;

	sfwf_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({arrival_time_us, pkt_len}),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	sfwf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ring bookkeeping for the arrival being accepted, ram read fields and datapath next values
	always_comb begin
		n_new      = (n_q < CNT_W'(WINDOW)) ? n_q + 1'b1 : n_q;
		slot_nx    = (slot_q == ADDR_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
		start_sum  = {1'b0, slot_nx} + (ADDR_W+1)'(WINDOW) - (ADDR_W+1)'(n_new);
		start_addr = (start_sum >= (ADDR_W+1)'(WINDOW)) ?
			ADDR_W'(start_sum - (ADDR_W+1)'(WINDOW)) : start_sum[ADDR_W-1:0];
		gaps       = n_q - 1'b1;
		rd_ts      = ram_rdata[RAM_W-1 -: TS_W];
		rd_sz      = ram_rdata[SZ_W-1:0];
		out_free   = !out_valid || !out_stall;
		mul_p_next = mul_p_q + (mul_b_q[0] ? mul_a_q : '0);
		mul_last   = (step_q == STEP_W'(SUM_W - 1));
		sq_last    = (step_q == STEP_W'(ROOT_W - 1));
		sq_rem2    = {sq_rem_q[REM_W-3:0], sq_val_q[SQV_W-1 -: 2]};
		sq_trial   = REM_W'({sq_root_q, 2'b01});
		sq_take    = (sq_rem2 >= sq_trial);
		sq_root_nx = {sq_root_q[ROOT_W-2:0], sq_take};
		n_wide     = 16'(n_q);
		pkts_us    = PRATE_W'(n_q) * PRATE_W'(US_PER_S);
		octets_us  = BRATE_W'(total_q) * BRATE_W'(US_PER_S);
		gaps_sq    = (2*CNT_W)'(gaps) * (2*CNT_W)'(gaps);
	end

	// next state
	always_comb begin
		nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) nxt = (n_new < CNT_W'(2)) ? ST_OUT : ST_SWEEP;
			ST_SWEEP: if (rd_cnt_q == gaps) nxt = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2 && !v_s3) nxt = ST_SQR;
			ST_SQR:   if (mul_last) nxt = ST_NUM;
			ST_NUM:   if (mul_last) nxt = ST_PREP;
			ST_PREP:  nxt = ST_VAR;
			ST_VAR:   if (div_rsp.done) nxt = ST_SQRT;
			ST_SQRT:  if (sq_last) nxt = ST_MEAN;
			ST_MEAN:  if (div_rsp.done) nxt = ST_PRATE;
			ST_PRATE: if (div_rsp.done) nxt = ST_BRATE;
			ST_BRATE: if (div_rsp.done) nxt = ST_SIZE;
			ST_SIZE:  if (div_rsp.done) nxt = ST_OUT;
			ST_OUT:   if (out_free) nxt = ST_IDLE;
			default:  nxt = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall         = (state_q != ST_IDLE);
		accept           = in_valid && !in_stall;
		ram_we           = accept;
		ram_re           = (state_q == ST_SWEEP);
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		if (state_q != nxt) begin
			unique case (nxt)
				ST_VAR: begin
					div_req.start    = 1'b1;
					div_req.dividend = (num_q >= NUM_W'(s2_q)) ? num_q - NUM_W'(s2_q) : '0;
					div_req.divisor  = DVS_W'(gaps_sq);
				end
				ST_MEAN: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(sum_q);
					div_req.divisor  = DVS_W'(gaps);
				end
				ST_PRATE: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(pkts_us);
					div_req.divisor  = span_q;
				end
				ST_BRATE: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(octets_us);
					div_req.divisor  = span_q;
				end
				ST_SIZE: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(total_q);
					div_req.divisor  = DVS_W'(n_q);
				end
				default: div_req.start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slot_q    <= '0;
			n_q       <= '0;
			rd_cnt_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= nxt;
			if (accept) begin
				slot_q   <= slot_nx;
				n_q      <= n_new;
				rd_cnt_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1 && !first_s1;
			v_s3 <= v_s2;
			if (state_q == ST_OUT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// sweep datapath: gap, split square, accumulate
	always_ff @(posedge clk) begin
		first_s1 <= (rd_cnt_q == '0);
		if (accept) begin
			t_q       <= arrival_time_us;
			short_q   <= (n_new < CNT_W'(2));
			rd_addr_q <= start_addr;
			total_q   <= '0;
			sum_q     <= '0;
			sumsq_q   <= '0;
		end else begin
			if (state_q == ST_SWEEP) begin
				rd_addr_q <= (rd_addr_q == ADDR_W'(WINDOW - 1)) ? '0 : rd_addr_q + 1'b1;
			end
			if (v_s1) begin
				total_q <= total_q + TOT_W'(rd_sz);
				prev_q  <= rd_ts;
				g_s2    <= rd_ts - prev_q;
				if (first_s1) begin
					first_q <= rd_ts;
				end
			end
			if (v_s2) begin
				sum_q <= sum_q + SUM_W'(g_s2);
				hh_s3 <= g_s2[TS_W-1:HALF_W] * g_s2[TS_W-1:HALF_W];
				hl_s3 <= g_s2[TS_W-1:HALF_W] * g_s2[HALF_W-1:0];
				ll_s3 <= g_s2[HALF_W-1:0] * g_s2[HALF_W-1:0];
			end
			if (v_s3) begin
				sumsq_q <= sumsq_q + (SQ_W'(hh_s3) << (2 * HALF_W))
					+ (SQ_W'(hl_s3) << (HALF_W + 1)) + SQ_W'(ll_s3);
			end
		end
	end

	// shift-add multiplier, square root and result capture
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DRAIN: begin
				span_q  <= t_q - first_q;
				mul_a_q <= PROD_W'(sum_q);
				mul_b_q <= sum_q;
				mul_p_q <= '0;
				step_q  <= '0;
			end
			ST_SQR, ST_NUM: begin
				if (mul_last && state_q == ST_SQR) begin
					s2_q    <= mul_p_next[2*SUM_W-1:0];
					mul_a_q <= PROD_W'(sumsq_q);
					mul_b_q <= SUM_W'(gaps);
					mul_p_q <= '0;
					step_q  <= '0;
				end else begin
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
					mul_p_q <= mul_p_next;
					step_q  <= step_q + 1'b1;
					if (mul_last) begin
						num_q <= mul_p_next[NUM_W-1:0];
					end
				end
			end
			ST_VAR: begin
				sq_val_q  <= div_rsp.quotient[SQV_W-1:0];
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				step_q    <= '0;
			end
			ST_SQRT: begin
				sq_val_q  <= sq_val_q << 2;
				sq_rem_q  <= sq_take ? sq_rem2 - sq_trial : sq_rem2;
				sq_root_q <= sq_root_nx;
				step_q    <= step_q + 1'b1;
				if (sq_last) begin
					std_q <= sq_root_nx[TS_W-1:0];
				end
			end
			ST_MEAN:  if (div_rsp.done) mean_q <= div_rsp.quotient[TS_W-1:0];
			ST_PRATE: begin
				if (div_rsp.done) begin
					prate_q <= (span_q == '0) ? '0 :
						(|div_rsp.quotient[DVD_W-1:PRATE_W]) ? '1 :
						div_rsp.quotient[PRATE_W-1:0];
				end
			end
			ST_BRATE: begin
				if (div_rsp.done) begin
					brate_q <= (span_q == '0) ? '0 :
						(|div_rsp.quotient[DVD_W-1:BRATE_W]) ? '1 :
						div_rsp.quotient[BRATE_W-1:0];
				end
			end
			ST_SIZE:  if (div_rsp.done) msize_q <= div_rsp.quotient[SZ_W-1:0];
			default:  step_q <= step_q;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			gap_mean_us <= short_q ? '0 : mean_q;
			gap_std_us  <= short_q ? '0 : std_q;
			packet_rate <= short_q ? '0 : prate_q;
			octet_rate  <= short_q ? '0 : brate_q;
			mean_size   <= short_q ? '0 : msize_q;
			duration_us <= short_q ? '0 : span_q;
			fill_count  <= (n_wide > 16'(FILL_MAX)) ? FILL_W'(FILL_MAX) : FILL_W'(n_wide);
		end
	end

	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("division started while divider busy");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> rd_cnt_q < n_q)
		else $error("ring sweep read past held arrivals");

	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQR |-> !v_s1 && !v_s2 && !v_s3)
		else $error("multiply started before sweep pipeline drained");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(WINDOW))
		else $error("held count beyond window");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result shown without finishing an item");

endmodule

[sim/tb_top.sv]
// testbench for sliding_window_flow_features: random and directed packet arrivals,
// a scoreboard class predicts every feature set; depends on sfwf_pkg and the block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfwf_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 800;

	typedef struct {
		logic [39:0] gap_mean;
		logic [39:0] gap_std;
		logic [25:0] prate;
		logic [41:0] brate;
		logic [15:0] msize;
		logic [39:0] span;
		logic [6:0]  fill;
	} features_t;

	class flow_scoreboard;
		logic [TS_W-1:0] ts_ring[WINDOW];
		logic [SZ_W-1:0] sz_ring[WINDOW];
		int              next_slot;
		int              held;
		features_t       pending_q[$];
		int              errors;

		function new();
			next_slot = 0;
			held = 0;
			errors = 0;
		endfunction

		task report(string field, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		endtask

		function void note_arrival(logic [39:0] t, logic [15:0] s);
			features_t   f;
			int          n, first_slot, idx, gaps;
			logic [39:0] prev, g, first_t, last_t;
			logic [63:0] sum, total;
			logic [127:0] sumsq, num, s2, var_q, root, c;
			ts_ring[next_slot] = t;
			sz_ring[next_slot] = s;
			next_slot = (next_slot + 1) % WINDOW;
			if (held < WINDOW) held++;
			n = held;
			f = '{default: '0};
			f.fill = 7'(n);
			if (n >= 2) begin
				first_slot = (next_slot + WINDOW - n) % WINDOW;
				first_t = ts_ring[first_slot];
				last_t = ts_ring[(next_slot + WINDOW - 1) % WINDOW];
				prev = first_t;
				sum = 0;
				total = 0;
				sumsq = 0;
				for (int i = 0; i < n; i++) begin
					idx = (first_slot + i) % WINDOW;
					total += sz_ring[idx];
					if (i > 0) begin
						g = ts_ring[idx] - prev;
						sum += g;
						sumsq += 128'(g) * 128'(g);
						prev = ts_ring[idx];
					end
				end
				gaps = n - 1;
				num = sumsq * gaps;
				s2 = 128'(sum) * 128'(sum);
				var_q = (num < s2) ? 128'd0 : (num - s2) / (gaps * gaps);
				root = 0;
				for (int b = 41; b >= 0; b--) begin
					c = root | (128'd1 << b);
					if (c * c <= var_q) root = c;
				end
				f.span = last_t - first_t;
				if (f.span != 0) begin
					f.prate = 26'((64'(n) * 1000000) / f.span);
					f.brate = 42'((total * 1000000) / f.span);
				end
				f.gap_mean = 40'(sum / gaps);
				f.gap_std = root[39:0];
				f.msize = 16'(total / n);
			end
			pending_q.push_back(f);
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		task check_result(features_t got);
			features_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("result with no arrival waiting at %0t", $realtime);
			end else begin
				want = pending_q.pop_front();
				if (got.gap_mean !== want.gap_mean) report("gap_mean_us", got.gap_mean, want.gap_mean);
				if (got.gap_std !== want.gap_std) report("gap_std_us", got.gap_std, want.gap_std);
				if (got.prate !== want.prate) report("packet_rate", got.prate, want.prate);
				if (got.brate !== want.brate) report("octet_rate", got.brate, want.brate);
				if (got.msize !== want.msize) report("mean_size", got.msize, want.msize);
				if (got.span !== want.span) report("duration_us", got.span, want.span);
				if (got.fill !== want.fill) report("fill_count", got.fill, want.fill);
			end
		endtask
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [TS_W-1:0]   arrival_time_us = '0;
	logic [SZ_W-1:0]   pkt_len = '0;
	logic              out_valid;
	logic              out_stall = 1;
	logic [39:0]       gap_mean_us, gap_std_us, duration_us;
	logic [25:0]       packet_rate;
	logic [41:0]       octet_rate;
	logic [15:0]       mean_size;
	logic [6:0]        fill_count;

	flow_scoreboard flows = new();
	int             idle_count = 0;
	int             results_seen = 0;
	logic [39:0]    last_t = '0;

	sliding_window_flow_features dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		features_t got;
		if (arst_n) begin
			idle_count++;
			if (in_valid && !in_stall) begin
				flows.note_arrival(arrival_time_us, pkt_len);
				idle_count = 0;
			end
			if (out_valid && !out_stall) begin
				got = '{gap_mean_us, gap_std_us, packet_rate, octet_rate, mean_size,
					duration_us, fill_count};
				flows.check_result(got);
				results_seen++;
				idle_count = 0;
			end
			if (idle_count >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			k = $urandom_range(0, 5);
			if ($urandom_range(0, 9) < 3) k = 0;
			if (results_seen == 300) k = HOLD_CYCLES;
			repeat (k) @(negedge clk) out_stall <= 1;
			@(negedge clk) out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task send_arrival(logic [39:0] t, logic [15:0] s, int gap);
		repeat (gap) @(negedge clk) in_valid <= 0;
		@(negedge clk);
		in_valid <= 1;
		arrival_time_us <= t;
		pkt_len <= s;
		last_t = t;
		do @(posedge clk); while (in_stall);
	endtask

	function logic [39:0] next_time();
		int          pick;
		logic [63:0] r;
		pick = $urandom_range(0, 99);
		r = {$urandom, $urandom};
		if (pick < 70) return last_t + 40'($urandom_range(1, 2000));
		else if (pick < 78) return last_t + r[39:0] % 40'd100000000;
		else if (pick < 84) return r[39:0];
		else if (pick < 92) return last_t;
		else return last_t - 40'($urandom_range(1, 500));
	endfunction

	function logic [15:0] next_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		// single arrival, then zero span, extremes and a wrap of the timestamp
		send_arrival(40'd0, 16'd0, 0);
		send_arrival(40'd0, 16'hFFFF, 0);
		send_arrival(40'hFF_FFFF_FFFF, 16'hFFFF, 1);
		send_arrival(40'd5, 16'd1, 0);
		send_arrival(40'd3, 16'd1500, 2);
		send_arrival(40'h80_0000_0000, 16'h8000, 0);
		send_arrival(40'h80_0000_0000, 16'h7FFF, 0);
		for (int i = 0; i < 16; i++)
			send_arrival(last_t + 40'd1, 16'hFFFF, $urandom_range(0, 5));
		for (int i = 0; i < 1430; i++)
			send_arrival(next_time(), next_size(),
				($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 5));
		@(negedge clk) in_valid <= 0;
		while (flows.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (flows.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

[filelist.f]
sv/sfwf_pkg.sv
sv/sfwf_ram.sv
sv/sfwf_div.sv
sv/sliding_window_flow_features.sv
sim/tb_top.sv
